[src/bhs_pkg.sv]
// Shared types, constants and helper functions of the boiler heating sequencer.
package bhs_pkg;

   localparam int unsigned InitialWaitSecs = 10;
   localparam int unsigned AlarmWindowSecs = 900;
   localparam int unsigned ForcedHeatLimit = 30;
   localparam int unsigned BandMargin      = 3;

   localparam int unsigned CsrIdxWidth  = 3;
   localparam int unsigned CsrDataWidth = 16;

   localparam logic [6:0]  TargetTempReset      = 7'd60;
   localparam logic [4:0]  HystBandReset        = 5'd5;
   localparam logic [4:0]  HystOffsetReset      = 5'd1;
   localparam logic [6:0]  MinOperTempReset     = 7'd5;
   localparam logic [15:0] PumpOverrunSecsReset = 16'd60;
   localparam logic [7:0]  ShortWaitSecsReset   = 8'd5;
   localparam logic [7:0]  StageWaitSecsReset   = 8'd30;
   localparam logic [7:0]  CirculateSecsReset   = 8'd60;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_TARGET_TEMP       = 3'd0,
      CSR_HYSTERESIS_BAND   = 3'd1,
      CSR_HYSTERESIS_OFFSET = 3'd2,
      CSR_MIN_OPER_TEMP     = 3'd3,
      CSR_PUMP_OVERRUN_SECS = 3'd4,
      CSR_SHORT_WAIT_SECS   = 3'd5,
      CSR_STAGE_WAIT_SECS   = 3'd6,
      CSR_CIRCULATE_SECS    = 3'd7
   } bhs_csr_type;

   typedef struct packed {
      logic [6:0]  target_temp;
      logic [4:0]  hysteresis_band;
      logic [4:0]  hysteresis_offset;
      logic [6:0]  min_operating_temp;
      logic [15:0] pump_overrun_secs;
      logic [7:0]  short_wait_secs;
      logic [7:0]  stage_wait_secs;
      logic [7:0]  circulate_secs;
   } bhs_cfg_type;

   typedef struct packed {
      logic        run_enable;
      logic [11:0] water_temp;
      logic        sensor_valid;
      logic        thermostat_demand;
      logic        second_strobe;
   } bhs_in_type;

   typedef struct packed {
      logic        pump_on;
      logic        heater_one_on;
      logic        heater_two_on;
      logic        heater_three_on;
      logic        low_temp_alarm;
      logic [5:0]  step_code;
      logic [11:0] accumulated_temp;
   } bhs_res_type;

   typedef enum logic [21:0] {
      ST_START        = 22'h000001,
      ST_PRERUN       = 22'h000002,
      ST_CHECK        = 22'h000004,
      ST_ALARM        = 22'h000008,
      ST_ALARM_WAIT   = 22'h000010,
      ST_FORCED       = 22'h000020,
      ST_HEAT_OFF     = 22'h000040,
      ST_OVERRUN      = 22'h000080,
      ST_WINDOW       = 22'h000100,
      ST_CIRCULATE    = 22'h000200,
      ST_DEMAND       = 22'h000400,
      ST_STAGE_INIT   = 22'h000800,
      ST_STAGE_ON     = 22'h001000,
      ST_STAGE_WAIT   = 22'h002000,
      ST_BAND         = 22'h004000,
      ST_LOW_SET      = 22'h008000,
      ST_LOW_STEP     = 22'h010000,
      ST_SETTLE       = 22'h020000,
      ST_HIGH_SET     = 22'h040000,
      ST_HIGH_STEP    = 22'h080000,
      ST_HIGH_OFF     = 22'h100000,
      ST_HIGH_OVERRUN = 22'h200000
   } bhs_state_type;

   // Numbering of the original sequence description.
   function automatic logic [5:0] step_number(bhs_state_type st);
      logic [5:0] num;
      num = 6'd0;
      unique case (st)
         ST_START:        num = 6'd0;
         ST_PRERUN:       num = 6'd1;
         ST_CHECK:        num = 6'd2;
         ST_ALARM:        num = 6'd3;
         ST_ALARM_WAIT:   num = 6'd4;
         ST_FORCED:       num = 6'd5;
         ST_HEAT_OFF:     num = 6'd6;
         ST_OVERRUN:      num = 6'd7;
         ST_WINDOW:       num = 6'd10;
         ST_CIRCULATE:    num = 6'd11;
         ST_DEMAND:       num = 6'd12;
         ST_STAGE_INIT:   num = 6'd13;
         ST_STAGE_ON:     num = 6'd14;
         ST_STAGE_WAIT:   num = 6'd15;
         ST_BAND:         num = 6'd20;
         ST_LOW_SET:      num = 6'd21;
         ST_LOW_STEP:     num = 6'd22;
         ST_SETTLE:       num = 6'd23;
         ST_HIGH_SET:     num = 6'd30;
         ST_HIGH_STEP:    num = 6'd31;
         ST_HIGH_OFF:     num = 6'd32;
         ST_HIGH_OVERRUN: num = 6'd33;
         default:         num = 6'd0;
      endcase
      return num;
   endfunction

   // Whole degrees to 1/16 degree.
   function automatic logic signed [15:0] x16(logic signed [15:0] v);
      return v <<< 4;
   endfunction

   // Clamp to the 12-bit signed range of the temperature mark.
   function automatic logic signed [11:0] sat12(logic signed [15:0] v);
      logic signed [11:0] r;
      if (v > 16'sd2047) begin
         r = 12'sd2047;
      end else if (v < -16'sd2048) begin
         r = -12'sd2048;
      end else begin
         r = v[11:0];
      end
      return r;
   endfunction

endpackage

[src/bhs_step.sv]
// Sequence state, second counters and the one-tick step logic of the heating sequencer.
module bhs_step (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  bhs_pkg::bhs_in_type  item,
   input  bhs_pkg::bhs_cfg_type cfg,
   output bhs_pkg::bhs_res_type result
);
   import bhs_pkg::*;

   localparam logic signed [15:0] MarginS    = 16'(BandMargin);
   localparam logic signed [15:0] ForcedS    = x16(16'(ForcedHeatLimit));
   localparam logic [15:0]        InitWait   = 16'(InitialWaitSecs);
   localparam logic [15:0]        AlarmWin   = 16'(AlarmWindowSecs);

   bhs_state_type     state_ff, state_in;
   logic              pump_ff, pump_in;
   logic [2:0]        heat_ff, heat_in;
   logic              alarm_ff, alarm_in;
   logic              pump_run_ff, pump_run_in;
   logic [15:0]       pump_sec_ff, pump_sec_in;
   logic [15:0]       win_sec_ff, win_sec_in;
   logic [1:0]        next_heat_ff, next_heat_in;
   logic signed [8:0] low_thr_ff, low_thr_in;
   logic signed [8:0] high_thr_ff, high_thr_in;
   logic signed [11:0] mark_ff, mark_in;

   logic signed [15:0] t16, tgt, band, offs, mark16, lt16, ht16;
   logic signed [15:0] hi_lim, lo_lim, enter_lim;
   logic               below_limit;

   assign t16       = {{4{item.water_temp[11]}}, item.water_temp};
   assign tgt       = {9'd0, cfg.target_temp};
   assign band      = {11'd0, cfg.hysteresis_band};
   assign offs      = {11'd0, cfg.hysteresis_offset};
   assign mark16    = {{4{mark_ff[11]}}, mark_ff};
   assign lt16      = {{7{low_thr_ff[8]}}, low_thr_ff};
   assign ht16      = {{7{high_thr_ff[8]}}, high_thr_ff};
   assign hi_lim    = tgt - offs;
   assign lo_lim    = tgt - band + offs;
   assign enter_lim = tgt - band - MarginS + offs;
   assign below_limit = (t16 < x16({9'd0, cfg.min_operating_temp})) && item.sensor_valid;

   always_comb begin
      logic signed [15:0] lim;
      logic [2:0]         hbit;
      lim          = '0;
      hbit         = '0;
      state_in     = state_ff;
      pump_in      = pump_ff;
      heat_in      = heat_ff;
      alarm_in     = alarm_ff;
      pump_run_in  = pump_run_ff;
      pump_sec_in  = pump_sec_ff;
      win_sec_in   = win_sec_ff;
      next_heat_in = next_heat_ff;
      low_thr_in   = low_thr_ff;
      high_thr_in  = high_thr_ff;
      mark_in      = mark_ff;
      if (item.run_enable) begin
         // count first, so a timer restart later in the tick wins
         if (item.second_strobe) begin
            if (win_sec_ff != '1) begin
               win_sec_in = win_sec_ff + 16'd1;
            end
            if (pump_run_ff && (pump_sec_ff != '1)) begin
               pump_sec_in = pump_sec_ff + 16'd1;
            end
         end
         unique case (state_ff)
            ST_START: begin
               pump_in = 1'b1; pump_sec_in = '0; pump_run_in = 1'b1;
               state_in = ST_PRERUN;
            end
            ST_PRERUN: begin
               if (pump_sec_in > InitWait) begin
                  pump_sec_in = '0; pump_run_in = 1'b0; state_in = ST_CHECK;
               end
            end
            ST_CHECK: begin
               state_in = below_limit ? ST_ALARM : ST_WINDOW;
            end
            ST_ALARM: begin
               alarm_in = 1'b1; pump_sec_in = '0; pump_run_in = 1'b1;
               state_in = ST_ALARM_WAIT;
            end
            ST_ALARM_WAIT: begin
               if (pump_sec_in > {8'd0, cfg.short_wait_secs}) begin
                  win_sec_in = '0; pump_sec_in = '0; pump_run_in = 1'b0;
                  state_in = ST_FORCED;
               end
            end
            ST_FORCED: begin
               if ((t16 < ForcedS) && (win_sec_in < AlarmWin)) begin
                  pump_in = 1'b1; heat_in = 3'b111;
               end else begin
                  state_in = ST_HEAT_OFF;
               end
            end
            ST_HEAT_OFF: begin
               alarm_in = 1'b0; heat_in = '0; pump_sec_in = '0; pump_run_in = 1'b1;
               state_in = ST_OVERRUN;
            end
            ST_OVERRUN: begin
               if (pump_sec_in > cfg.pump_overrun_secs) begin
                  pump_sec_in = '0; pump_run_in = 1'b0;
                  if (t16 > x16(tgt)) begin
                     pump_in = 1'b0;
                  end
                  state_in = ST_CHECK;
               end
            end
            ST_WINDOW: begin
               if (win_sec_in > AlarmWin) begin
                  pump_in = 1'b1; pump_sec_in = '0; pump_run_in = 1'b1;
                  win_sec_in = '0; state_in = ST_CIRCULATE;
               end else begin
                  state_in = ST_DEMAND;
               end
            end
            ST_CIRCULATE: begin
               if (pump_sec_in > {8'd0, cfg.circulate_secs}) begin
                  pump_sec_in = '0; pump_run_in = 1'b0; state_in = ST_DEMAND;
               end
            end
            ST_DEMAND: begin
               state_in = item.thermostat_demand ? ST_STAGE_INIT : ST_HEAT_OFF;
            end
            ST_STAGE_INIT: begin
               next_heat_in = '0;
               if (t16 >= x16(enter_lim)) begin
                  state_in = ST_BAND;
               end else begin
                  heat_in = '0; pump_in = 1'b1; state_in = ST_STAGE_ON;
               end
            end
            ST_STAGE_ON: begin
               pump_sec_in = '0; pump_run_in = 1'b1;
               // round robin over the three elements; index three is kept
               case (next_heat_ff)
                  2'd0: begin heat_in = heat_ff | 3'b001; next_heat_in = 2'd1; end
                  2'd1: begin heat_in = heat_ff | 3'b010; next_heat_in = 2'd2; end
                  2'd2: begin heat_in = heat_ff | 3'b100; next_heat_in = 2'd0; end
                  default: ;
               endcase
               state_in = ST_STAGE_WAIT;
            end
            ST_STAGE_WAIT: begin
               if (pump_sec_in > {8'd0, cfg.stage_wait_secs}) begin
                  state_in = ST_STAGE_ON;
               end else if (item.thermostat_demand && (t16 > x16(hi_lim))) begin
                  mark_in = sat12(x16(hi_lim));
                  pump_sec_in = '0; pump_run_in = 1'b0; state_in = ST_BAND;
               end else if (!item.thermostat_demand) begin
                  state_in = ST_HEAT_OFF;
               end else if (below_limit) begin
                  state_in = ST_ALARM; win_sec_in = '0;
               end
            end
            ST_BAND: begin
               if (t16 > x16(hi_lim)) begin
                  state_in = ST_HIGH_SET;
               end else if (t16 < x16(lo_lim)) begin
                  state_in = ST_LOW_SET;
               end else begin
                  state_in = ST_SETTLE;
               end
            end
            ST_LOW_SET: begin
               pump_in = 1'b1; state_in = ST_LOW_STEP; low_thr_in = lo_lim[8:0];
            end
            ST_LOW_STEP: begin
               // lower the mark to the band edge and switch that element on
               if (t16 > x16(lt16 - 16'sd1)) begin
                  lim = x16(lt16 - 16'sd1); hbit = 3'b001;
               end else if (t16 > x16(lt16 - 16'sd2)) begin
                  lim = x16(lt16 - 16'sd2); hbit = 3'b010;
               end else begin
                  lim = x16(lt16 - 16'sd3); hbit = 3'b100;
               end
               if (mark16 > lim) begin
                  mark_in = sat12(lim); heat_in = heat_ff | hbit;
               end
               pump_sec_in = '0; pump_run_in = 1'b1; state_in = ST_SETTLE;
            end
            ST_SETTLE: begin
               if (pump_sec_in > {8'd0, cfg.short_wait_secs}) begin
                  pump_sec_in = '0; pump_run_in = 1'b0; state_in = ST_CHECK;
               end
            end
            ST_HIGH_SET: begin
               state_in = ST_HIGH_STEP; high_thr_in = hi_lim[8:0];
            end
            ST_HIGH_STEP: begin
               if (t16 > x16(ht16 + 16'sd2)) begin
                  mark_in = sat12(x16(ht16 + 16'sd2)); state_in = ST_HIGH_OFF;
               end else begin
                  // raise the mark to the band edge and switch that element off
                  if (t16 > x16(ht16 + 16'sd1)) begin
                     lim = x16(ht16 + 16'sd1); hbit = 3'b010;
                  end else begin
                     lim = x16(ht16); hbit = 3'b100;
                  end
                  if (mark16 < lim) begin
                     mark_in = sat12(lim); heat_in = heat_ff & ~hbit;
                  end
                  pump_sec_in = '0; pump_run_in = 1'b1; state_in = ST_SETTLE;
               end
            end
            ST_HIGH_OFF: begin
               heat_in = '0; pump_sec_in = '0; pump_run_in = 1'b1;
               state_in = ST_HIGH_OVERRUN;
            end
            ST_HIGH_OVERRUN: begin
               if (pump_sec_in > cfg.pump_overrun_secs) begin
                  pump_sec_in = '0; pump_run_in = 1'b1;
                  if (t16 > x16(ht16)) begin
                     pump_in = 1'b0;
                  end else begin
                     pump_in = 1'b1; win_sec_in = '0;
                  end
                  state_in = ST_SETTLE;
               end else if (t16 < x16(ht16)) begin
                  pump_sec_in = '0; pump_run_in = 1'b1; state_in = ST_SETTLE;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_START;
         pump_ff      <= 1'b0;
         heat_ff      <= '0;
         alarm_ff     <= 1'b0;
         pump_run_ff  <= 1'b0;
         pump_sec_ff  <= '0;
         win_sec_ff   <= '0;
         next_heat_ff <= '0;
         low_thr_ff   <= '0;
         high_thr_ff  <= '0;
         mark_ff      <= '0;
      end else if (take) begin
         state_ff     <= state_in;
         pump_ff      <= pump_in;
         heat_ff      <= heat_in;
         alarm_ff     <= alarm_in;
         pump_run_ff  <= pump_run_in;
         pump_sec_ff  <= pump_sec_in;
         win_sec_ff   <= win_sec_in;
         next_heat_ff <= next_heat_in;
         low_thr_ff   <= low_thr_in;
         high_thr_ff  <= high_thr_in;
         mark_ff      <= mark_in;
      end
   end

   // The word shows the state after this tick.
   assign result.pump_on          = pump_in;
   assign result.heater_one_on    = heat_in[0];
   assign result.heater_two_on    = heat_in[1];
   assign result.heater_three_on  = heat_in[2];
   assign result.low_temp_alarm   = alarm_in;
   assign result.step_code        = step_number(state_in);
   assign result.accumulated_temp = mark_in;

   a_idle_timer_clear: assert property (@(posedge clock) disable iff (reset)
      !pump_run_ff |-> (pump_sec_ff == '0))
      else $error("pump timer holds a count while stopped");

   a_alarm_steps: assert property (@(posedge clock) disable iff (reset)
      alarm_ff |-> (state_ff == ST_ALARM_WAIT || state_ff == ST_FORCED ||
                    state_ff == ST_HEAT_OFF))
      else $error("alarm flag set outside the alarm sequence");

   a_heater_index: assert property (@(posedge clock) disable iff (reset)
      next_heat_ff != 2'd3)
      else $error("staging index out of range");

endmodule

[src/boiler_heating_sequencer.sv]
// Top level of the boiler heating sequencer: ports, control registers and word buffering.
//
// One request word is one control tick and yields exactly one response word that shows
// the pump, element and alarm drives, the step number and the temperature mark after
// that tick. The block takes a word every clock cycle while the skid register is empty:
// a request is held in the input register, the step logic works on it combinationally,
// and the response is written to the output register, which drives rsp_valid.
// A skid register behind the output holds one more word when the response side stalls,
// and req_ready comes from registers only. Write control registers only while no word
// is in flight.
module boiler_heating_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_run_enable,
   input  logic signed [11:0]                req_water_temp,
   input  logic                              req_sensor_valid,
   input  logic                              req_thermostat_demand,
   input  logic                              req_second_strobe,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_pump_on,
   output logic                              rsp_heater_one_on,
   output logic                              rsp_heater_two_on,
   output logic                              rsp_heater_three_on,
   output logic                              rsp_low_temp_alarm,
   output logic [5:0]                        rsp_step_code,
   output logic signed [11:0]                rsp_accumulated_temp,
   input  logic                              csr_wr_en,
   input  logic [bhs_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [bhs_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import bhs_pkg::*;

   bhs_cfg_type cfg_ff;
   bhs_in_type  in_ff;
   logic        in_valid_ff;
   bhs_res_type out_ff, skid_ff, res;
   logic        out_valid_ff, skid_valid_ff;
   logic        take, out_load;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_temp        <= TargetTempReset;
         cfg_ff.hysteresis_band    <= HystBandReset;
         cfg_ff.hysteresis_offset  <= HystOffsetReset;
         cfg_ff.min_operating_temp <= MinOperTempReset;
         cfg_ff.pump_overrun_secs  <= PumpOverrunSecsReset;
         cfg_ff.short_wait_secs    <= ShortWaitSecsReset;
         cfg_ff.stage_wait_secs    <= StageWaitSecsReset;
         cfg_ff.circulate_secs     <= CirculateSecsReset;
      end else if (csr_wr_en) begin
         unique case (bhs_csr_type'(csr_index))
            CSR_TARGET_TEMP:       cfg_ff.target_temp        <= csr_wdata[6:0];
            CSR_HYSTERESIS_BAND:   cfg_ff.hysteresis_band    <= csr_wdata[4:0];
            CSR_HYSTERESIS_OFFSET: cfg_ff.hysteresis_offset  <= csr_wdata[4:0];
            CSR_MIN_OPER_TEMP:     cfg_ff.min_operating_temp <= csr_wdata[6:0];
            CSR_PUMP_OVERRUN_SECS: cfg_ff.pump_overrun_secs  <= csr_wdata[15:0];
            CSR_SHORT_WAIT_SECS:   cfg_ff.short_wait_secs    <= csr_wdata[7:0];
            CSR_STAGE_WAIT_SECS:   cfg_ff.stage_wait_secs    <= csr_wdata[7:0];
            CSR_CIRCULATE_SECS:    cfg_ff.circulate_secs     <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // advance the held word whenever the skid is free
   assign take      = in_valid_ff && !skid_valid_ff;
   assign req_ready = !in_valid_ff || !skid_valid_ff;
   assign out_load  = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (take) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff.run_enable        <= req_run_enable;
         in_ff.water_temp        <= req_water_temp;
         in_ff.sensor_valid      <= req_sensor_valid;
         in_ff.thermostat_demand <= req_thermostat_demand;
         in_ff.second_strobe     <= req_second_strobe;
      end
   end

   bhs_step u_step (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .item   (in_ff),
      .cfg    (cfg_ff),
      .result (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_valid_ff && rsp_ready) begin
         // drain the skid into the output, or drop the delivered word
         out_valid_ff  <= skid_valid_ff;
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         if (out_load) begin
            out_ff <= res;
         end else begin
            skid_ff <= res;
         end
      end else if (out_valid_ff && rsp_ready && skid_valid_ff) begin
         out_ff <= skid_ff;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_pump_on          = out_ff.pump_on;
   assign rsp_heater_one_on    = out_ff.heater_one_on;
   assign rsp_heater_two_on    = out_ff.heater_two_on;
   assign rsp_heater_three_on  = out_ff.heater_three_on;
   assign rsp_low_temp_alarm   = out_ff.low_temp_alarm;
   assign rsp_step_code        = out_ff.step_code;
   assign rsp_accumulated_temp = out_ff.accumulated_temp;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held with an empty output register");

endmodule

[test/testbench.sv]
// Self-checking testbench for the boiler heating sequencer: stimulus, tick predictor, checker.
`timescale 1ns / 100ps

module testbench;

   localparam logic [5:0] StepStart       = 6'd0;
   localparam logic [5:0] StepPrerun      = 6'd1;
   localparam logic [5:0] StepCheck       = 6'd2;
   localparam logic [5:0] StepAlarm       = 6'd3;
   localparam logic [5:0] StepAlarmWait   = 6'd4;
   localparam logic [5:0] StepForced      = 6'd5;
   localparam logic [5:0] StepHeatOff     = 6'd6;
   localparam logic [5:0] StepOverrun     = 6'd7;
   localparam logic [5:0] StepWindow      = 6'd10;
   localparam logic [5:0] StepCirculate   = 6'd11;
   localparam logic [5:0] StepDemand      = 6'd12;
   localparam logic [5:0] StepStageInit   = 6'd13;
   localparam logic [5:0] StepStageOn     = 6'd14;
   localparam logic [5:0] StepStageWait   = 6'd15;
   localparam logic [5:0] StepBand        = 6'd20;
   localparam logic [5:0] StepLowSet      = 6'd21;
   localparam logic [5:0] StepLowStep     = 6'd22;
   localparam logic [5:0] StepSettle      = 6'd23;
   localparam logic [5:0] StepHighSet     = 6'd30;
   localparam logic [5:0] StepHighStep    = 6'd31;
   localparam logic [5:0] StepHighOff     = 6'd32;
   localparam logic [5:0] StepHighOverrun = 6'd33;

   localparam int PrerunSecs   = int'(bhs_pkg::InitialWaitSecs);
   localparam int WindowSecs   = int'(bhs_pkg::AlarmWindowSecs);
   localparam int HeatLimitX16 = int'(bhs_pkg::ForcedHeatLimit) * 16;
   localparam int Margin       = int'(bhs_pkg::BandMargin);
   localparam int SecsMax      = 65535;
   localparam int LongHold     = 120;
   localparam int QuietLimit   = 2000;
   localparam int TempLow      = -880;
   localparam int TempHigh     = 2000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_run_enable = 1'b0;
   logic signed [11:0]   req_water_temp = '0;
   logic                 req_sensor_valid = 1'b0;
   logic                 req_thermostat_demand = 1'b0;
   logic                 req_second_strobe = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_pump_on;
   logic                 rsp_heater_one_on;
   logic                 rsp_heater_two_on;
   logic                 rsp_heater_three_on;
   logic                 rsp_low_temp_alarm;
   logic [5:0]           rsp_step_code;
   logic signed [11:0]   rsp_accumulated_temp;
   logic                 csr_wr_en = 1'b0;
   logic [bhs_pkg::CsrIdxWidth-1:0]  csr_index = '0;
   logic [bhs_pkg::CsrDataWidth-1:0] csr_wdata = '0;

   boiler_heating_sequencer u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_run_enable        (req_run_enable),
      .req_water_temp        (req_water_temp),
      .req_sensor_valid      (req_sensor_valid),
      .req_thermostat_demand (req_thermostat_demand),
      .req_second_strobe     (req_second_strobe),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_pump_on           (rsp_pump_on),
      .rsp_heater_one_on     (rsp_heater_one_on),
      .rsp_heater_two_on     (rsp_heater_two_on),
      .rsp_heater_three_on   (rsp_heater_three_on),
      .rsp_low_temp_alarm    (rsp_low_temp_alarm),
      .rsp_step_code         (rsp_step_code),
      .rsp_accumulated_temp  (rsp_accumulated_temp),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #2 clock = ~clock;

   // Control register copy
   logic [6:0]  cfg_target;
   logic [4:0]  cfg_band;
   logic [4:0]  cfg_offset;
   logic [6:0]  cfg_min_temp;
   logic [15:0] cfg_overrun;
   logic [7:0]  cfg_short_wait;
   logic [7:0]  cfg_stage_wait;
   logic [7:0]  cfg_circulate;

   // Sequencer state copy
   logic [5:0]  seq_step;
   logic        pump_drive;
   logic [2:0]  heater_drives;
   logic        alarm_flag;
   logic        pump_timing;
   int          pump_secs;
   int          window_secs;
   logic [1:0]  next_heater;
   int          low_limit_deg;
   int          high_limit_deg;
   int          temp_mark;
   bit          circulation_seen = 1'b0;

   bhs_pkg::bhs_in_type  pending_ticks[$];
   bhs_pkg::bhs_res_type expected_readings[$];
   bhs_pkg::bhs_in_type  offered;

   bit tx_gappy = 1'b0;
   bit rx_gappy = 1'b0;
   int tx_wait = 0;
   int rx_wait = 0;
   int words_seen = 0;
   int failures = 0;
   int quiet_cycles = 0;

   function automatic void restart_pump_timer(logic running);
      pump_secs   = 0;
      pump_timing = running;
   endfunction

   function automatic void store_mark(int v);
      if (v > 2047) v = 2047;
      if (v < -2048) v = -2048;
      temp_mark = v;
   endfunction

   // Pull the mark down to the limit and switch the element on.
   function automatic void lower_mark(logic [2:0] element, int limit16);
      if (temp_mark > limit16) begin
         store_mark(limit16);
         heater_drives = heater_drives | element;
      end
   endfunction

   // Push the mark up to the limit and switch the element off.
   function automatic void raise_mark(logic [2:0] element, int limit16);
      if (temp_mark < limit16) begin
         store_mark(limit16);
         heater_drives = heater_drives & ~element;
      end
   endfunction

   function automatic void reset_sequencer();
      cfg_target     = bhs_pkg::TargetTempReset;
      cfg_band       = bhs_pkg::HystBandReset;
      cfg_offset     = bhs_pkg::HystOffsetReset;
      cfg_min_temp   = bhs_pkg::MinOperTempReset;
      cfg_overrun    = bhs_pkg::PumpOverrunSecsReset;
      cfg_short_wait = bhs_pkg::ShortWaitSecsReset;
      cfg_stage_wait = bhs_pkg::StageWaitSecsReset;
      cfg_circulate  = bhs_pkg::CirculateSecsReset;
      seq_step       = StepStart;
      pump_drive     = 1'b0;
      heater_drives  = 3'b000;
      alarm_flag     = 1'b0;
      pump_timing    = 1'b0;
      pump_secs      = 0;
      window_secs    = 0;
      next_heater    = 2'd0;
      low_limit_deg  = 0;
      high_limit_deg = 0;
      temp_mark      = 0;
   endfunction

   // Advance the sequencer by one control tick and queue the resulting drive word.
   function automatic void sequence_tick(bhs_pkg::bhs_in_type tk);
      bhs_pkg::bhs_res_type r;
      int t;
      int tgt;
      int band;
      int offs;
      bit below;
      t     = int'($signed(tk.water_temp));
      tgt   = int'(cfg_target);
      band  = int'(cfg_band);
      offs  = int'(cfg_offset);
      below = (t < int'(cfg_min_temp) * 16) && tk.sensor_valid;
      if (tk.run_enable) begin
         // counters move before the step logic so a timer restart below wins
         if (tk.second_strobe) begin
            if (window_secs < SecsMax) window_secs++;
            if (pump_timing && pump_secs < SecsMax) pump_secs++;
         end
         case (seq_step)
            StepStart: begin
               pump_drive = 1'b1;
               restart_pump_timer(1'b1);
               seq_step = StepPrerun;
            end
            StepPrerun: begin
               if (pump_secs > PrerunSecs) begin
                  restart_pump_timer(1'b0);
                  seq_step = StepCheck;
               end
            end
            StepCheck: seq_step = below ? StepAlarm : StepWindow;
            StepAlarm: begin
               alarm_flag = 1'b1;
               restart_pump_timer(1'b1);
               seq_step = StepAlarmWait;
            end
            StepAlarmWait: begin
               if (pump_secs > int'(cfg_short_wait)) begin
                  window_secs = 0;
                  restart_pump_timer(1'b0);
                  seq_step = StepForced;
               end
            end
            StepForced: begin
               if (t < HeatLimitX16 && window_secs < WindowSecs) begin
                  pump_drive    = 1'b1;
                  heater_drives = 3'b111;
               end else begin
                  seq_step = StepHeatOff;
               end
            end
            StepHeatOff: begin
               alarm_flag    = 1'b0;
               heater_drives = 3'b000;
               restart_pump_timer(1'b1);
               seq_step = StepOverrun;
            end
            StepOverrun: begin
               if (pump_secs > int'(cfg_overrun)) begin
                  restart_pump_timer(1'b0);
                  if (t > tgt * 16) pump_drive = 1'b0;
                  seq_step = StepCheck;
               end
            end
            StepWindow: begin
               if (window_secs > WindowSecs) begin
                  pump_drive = 1'b1;
                  restart_pump_timer(1'b1);
                  window_secs = 0;
                  circulation_seen = 1'b1;
                  seq_step = StepCirculate;
               end else begin
                  seq_step = StepDemand;
               end
            end
            StepCirculate: begin
               if (pump_secs > int'(cfg_circulate)) begin
                  restart_pump_timer(1'b0);
                  seq_step = StepDemand;
               end
            end
            StepDemand: seq_step = tk.thermostat_demand ? StepStageInit : StepHeatOff;
            StepStageInit: begin
               next_heater = 2'd0;
               if (t >= (tgt - band - Margin + offs) * 16) begin
                  seq_step = StepBand;
               end else begin
                  heater_drives = 3'b000;
                  pump_drive    = 1'b1;
                  seq_step      = StepStageOn;
               end
            end
            StepStageOn: begin
               restart_pump_timer(1'b1);
               // index three switches nothing and stays
               case (next_heater)
                  2'd0: begin
                     heater_drives[0] = 1'b1;
                     next_heater = 2'd1;
                  end
                  2'd1: begin
                     heater_drives[1] = 1'b1;
                     next_heater = 2'd2;
                  end
                  2'd2: begin
                     heater_drives[2] = 1'b1;
                     next_heater = 2'd0;
                  end
                  default: ;
               endcase
               seq_step = StepStageWait;
            end
            StepStageWait: begin
               if (pump_secs > int'(cfg_stage_wait)) begin
                  seq_step = StepStageOn;
               end else if (tk.thermostat_demand && t > (tgt - offs) * 16) begin
                  store_mark((tgt - offs) * 16);
                  restart_pump_timer(1'b0);
                  seq_step = StepBand;
               end else if (!tk.thermostat_demand) begin
                  seq_step = StepHeatOff;
               end else if (below) begin
                  seq_step = StepAlarm;
                  window_secs = 0;
               end
            end
            StepBand: begin
               if (t > (tgt - offs) * 16) seq_step = StepHighSet;
               else if (t < (tgt - band + offs) * 16) seq_step = StepLowSet;
               else seq_step = StepSettle;
            end
            StepLowSet: begin
               pump_drive    = 1'b1;
               seq_step      = StepLowStep;
               low_limit_deg = tgt - band + offs;
            end
            StepLowStep: begin
               if (t > (low_limit_deg - 1) * 16)
                  lower_mark(3'b001, (low_limit_deg - 1) * 16);
               else if (t > (low_limit_deg - 2) * 16)
                  lower_mark(3'b010, (low_limit_deg - 2) * 16);
               else
                  lower_mark(3'b100, (low_limit_deg - 3) * 16);
               restart_pump_timer(1'b1);
               seq_step = StepSettle;
            end
            StepSettle: begin
               if (pump_secs > int'(cfg_short_wait)) begin
                  restart_pump_timer(1'b0);
                  seq_step = StepCheck;
               end
            end
            StepHighSet: begin
               seq_step       = StepHighStep;
               high_limit_deg = tgt - offs;
            end
            StepHighStep: begin
               if (t > (high_limit_deg + 2) * 16) begin
                  store_mark((high_limit_deg + 2) * 16);
                  seq_step = StepHighOff;
               end else begin
                  if (t > (high_limit_deg + 1) * 16)
                     raise_mark(3'b010, (high_limit_deg + 1) * 16);
                  else
                     raise_mark(3'b100, high_limit_deg * 16);
                  restart_pump_timer(1'b1);
                  seq_step = StepSettle;
               end
            end
            StepHighOff: begin
               heater_drives = 3'b000;
               restart_pump_timer(1'b1);
               seq_step = StepHighOverrun;
            end
            StepHighOverrun: begin
               if (pump_secs > int'(cfg_overrun)) begin
                  restart_pump_timer(1'b1);
                  if (t > high_limit_deg * 16) begin
                     pump_drive = 1'b0;
                  end else begin
                     pump_drive  = 1'b1;
                     window_secs = 0;
                  end
                  seq_step = StepSettle;
               end else if (t < high_limit_deg * 16) begin
                  restart_pump_timer(1'b1);
                  seq_step = StepSettle;
               end
            end
            default: ;
         endcase
      end
      r.pump_on          = pump_drive;
      r.heater_one_on    = heater_drives[0];
      r.heater_two_on    = heater_drives[1];
      r.heater_three_on  = heater_drives[2];
      r.low_temp_alarm   = alarm_flag;
      r.step_code        = seq_step;
      r.accumulated_temp = temp_mark[11:0];
      expected_readings.push_back(r);
   endfunction

   function automatic int draw_idle(bit gappy);
      if (!gappy || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 17);
   endfunction

   function automatic void queue_tick(bit run, int temp, bit valid, bit demand, bit strobe);
      bhs_pkg::bhs_in_type tk;
      if (temp < TempLow) temp = TempLow;
      if (temp > TempHigh) temp = TempHigh;
      tk.run_enable        = run;
      tk.water_temp        = temp[11:0];
      tk.sensor_valid      = valid;
      tk.thermostat_demand = demand;
      tk.second_strobe     = strobe;
      pending_ticks.push_back(tk);
   endfunction

   // Aim temperatures at the decision points of the current settings.
   function automatic int pick_temp();
      int tgt;
      int band;
      int offs;
      int v;
      tgt  = int'(cfg_target);
      band = int'(cfg_band);
      offs = int'(cfg_offset);
      case ($urandom_range(0, 5))
         0: v = int'($urandom_range(0, TempHigh - TempLow)) + TempLow;
         1: v = tgt * 16 + int'($urandom_range(0, 160)) - 80;
         2: v = int'(cfg_min_temp) * 16 + int'($urandom_range(0, 64)) - 32;
         3: v = (tgt - offs) * 16 + int'($urandom_range(0, 112)) - 40;
         4: v = (tgt - band + offs) * 16 + int'($urandom_range(0, 128)) - 80;
         default: v = HeatLimitX16 + int'($urandom_range(0, 64)) - 32;
      endcase
      return v;
   endfunction

   function automatic void queue_random_ticks(int count, int strobe_pct, bit soak);
      int lo;
      int hi;
      lo = int'(cfg_min_temp) * 16;
      hi = (int'(cfg_target) - int'(cfg_offset)) * 16;
      for (int i = 0; i < count; i++) begin
         if (soak)
            queue_tick(1'b1, int'($urandom_range(0, hi - lo)) + lo, 1'b1,
                       $urandom_range(0, 9) < 7, 1'b1);
         else
            queue_tick($urandom_range(0, 9) != 0, pick_temp(), $urandom_range(0, 6) != 0,
                       $urandom_range(0, 9) < 7, $urandom_range(0, 99) < strobe_pct);
      end
   endfunction

   task automatic write_register(bhs_pkg::bhs_csr_type idx, logic [15:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         bhs_pkg::CSR_TARGET_TEMP:       cfg_target     = data[6:0];
         bhs_pkg::CSR_HYSTERESIS_BAND:   cfg_band       = data[4:0];
         bhs_pkg::CSR_HYSTERESIS_OFFSET: cfg_offset     = data[4:0];
         bhs_pkg::CSR_MIN_OPER_TEMP:     cfg_min_temp   = data[6:0];
         bhs_pkg::CSR_PUMP_OVERRUN_SECS: cfg_overrun    = data;
         bhs_pkg::CSR_SHORT_WAIT_SECS:   cfg_short_wait = data[7:0];
         bhs_pkg::CSR_STAGE_WAIT_SECS:   cfg_stage_wait = data[7:0];
         bhs_pkg::CSR_CIRCULATE_SECS:    cfg_circulate  = data[7:0];
         default: ;
      endcase
   endtask

   // Write all eight registers in index order; widen sets junk above each field narrower than 16 bits.
   task automatic load_settings(int tgt, int band, int offs, int min_temp, int overrun,
                                int short_w, int stage_w, int circ, bit widen);
      int vals[8];
      int widths[8];
      logic [31:0] data;
      vals   = '{tgt, band, offs, min_temp, overrun, short_w, stage_w, circ};
      widths = '{7, 5, 5, 7, 16, 8, 8, 8};
      for (int i = 0; i < 8; i++) begin
         data = vals[i];
         if (widen) data = data | ($urandom_range(0, 65535) << widths[i]);
         write_register(bhs_pkg::bhs_csr_type'(i), data[15:0]);
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Hold until every queued word is in and out, then let the pipeline settle.
   task automatic drain();
      @(negedge clock);
      while (pending_ticks.size() != 0 || req_valid || expected_readings.size() != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic run_phase(int count, int strobe_pct, bit tx_idle, bit rx_idle);
      tx_gappy = tx_idle;
      rx_gappy = rx_idle;
      queue_random_ticks(count, strobe_pct, 1'b0);
      drain();
   endtask

   // Driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_wait = 0;
      end else begin
         if (req_valid && req_ready) sequence_tick(offered);
         if (!req_valid || req_ready) begin
            if (tx_wait > 0 || pending_ticks.size() == 0) begin
               if (tx_wait > 0) tx_wait--;
               req_valid <= 1'b0;
            end else begin
               offered = pending_ticks.pop_front();
               req_run_enable        <= offered.run_enable;
               req_water_temp        <= offered.water_temp;
               req_sensor_valid      <= offered.sensor_valid;
               req_thermostat_demand <= offered.thermostat_demand;
               req_second_strobe     <= offered.second_strobe;
               req_valid             <= 1'b1;
               tx_wait = draw_idle(tx_gappy);
            end
         end
      end
   end

   // Monitor
   always @(posedge clock) begin
      bhs_pkg::bhs_res_type observed;
      bhs_pkg::bhs_res_type wanted;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            observed = {rsp_pump_on, rsp_heater_one_on, rsp_heater_two_on, rsp_heater_three_on,
                        rsp_low_temp_alarm, rsp_step_code, rsp_accumulated_temp};
            if (expected_readings.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("word %0d arrived with nothing expected", words_seen);
            end else begin
               wanted = expected_readings.pop_front();
               if (observed !== wanted) begin
                  failures++;
                  if (failures <= 10) begin
                     $write("word %0d mismatch: expected pump %b heat %b%b%b alarm %b",
                            words_seen, wanted.pump_on, wanted.heater_three_on,
                            wanted.heater_two_on, wanted.heater_one_on,
                            wanted.low_temp_alarm);
                     $write(" step %0d mark %0d, got pump %b heat %b%b%b alarm %b",
                            wanted.step_code, $signed(wanted.accumulated_temp),
                            observed.pump_on, observed.heater_three_on,
                            observed.heater_two_on, observed.heater_one_on,
                            observed.low_temp_alarm);
                     $display(" step %0d mark %0d", observed.step_code,
                              $signed(observed.accumulated_temp));
                  end
               end
            end
            words_seen++;
            rx_wait = draw_idle(rx_gappy);
            // long back-pressure so the block fills and stalls its input
            if (words_seen == 150 || words_seen == 700) rx_wait = LongHold;
         end
         if (rx_wait > 0) begin
            rx_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("boiler_heating_sequencer test failed");
            $finish;
         end
      end
   end

   initial begin
      int soak_chunks;
      reset_sequencer();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: frozen tick, field extremes, pre-run, alarm and forced heating.
      tx_gappy = 1'b0;
      rx_gappy = 1'b1;
      queue_tick(1'b0, TempLow, 1'b1, 1'b1, 1'b1);
      queue_tick(1'b1, TempHigh, 1'b0, 1'b0, 1'b0);
      for (int i = 0; i < 11; i++)
         queue_tick(1'b1, i * 64 - 200, i[0], i[1], 1'b1);
      queue_tick(1'b1, TempLow, 1'b1, 1'b1, 1'b0);
      queue_tick(1'b1, 0, 1'b1, 1'b1, 1'b0);
      for (int i = 0; i < 6; i++)
         queue_tick(1'b1, 100 + i, 1'b1, 1'b0, 1'b1);
      queue_tick(1'b1, 0, 1'b1, 1'b1, 1'b0);
      queue_tick(1'b1, TempHigh, 1'b1, 1'b1, 1'b1);
      drain();

      run_phase(80, 60, 1'b1, 1'b1);

      load_settings(40, 6, 2, 12, 3, 1, 2, 3, 1'b0);
      run_phase(80, 50, 1'b0, 1'b1);

      load_settings(120, 31, 31, 120, 65535, 255, 255, 255, 1'b0);
      run_phase(40, 80, 1'b1, 1'b0);

      load_settings(0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
      run_phase(40, 50, 1'b1, 1'b1);

      // Steady strobes with no alarm let the circulation window expire.
      load_settings(50, 4, 2, 5, 2, 1, 2, 1, 1'b0);
      tx_gappy = 1'b0;
      rx_gappy = 1'b0;
      soak_chunks = 0;
      while (!circulation_seen && soak_chunks < 12) begin
         queue_random_ticks(100, 100, 1'b1);
         drain();
         soak_chunks++;
      end

      load_settings($urandom_range(0, 120), $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 120), $urandom_range(0, 8), $urandom_range(0, 6),
                    $urandom_range(0, 6), $urandom_range(0, 6), 1'b1);
      run_phase(50, 55, 1'b1, 1'b1);

      if (failures == 0 && expected_readings.size() == 0)
         $display("boiler_heating_sequencer test passed");
      else
         $display("boiler_heating_sequencer test failed");
      $finish;
   end

endmodule
